### src/sobet_pkg.sv
`default_nettype none
package sobet_pkg;

  // Register field widths
  localparam int FW_BITS  = 10;
  localparam int FH_BITS  = 12;
  localparam int THR_BITS = 11;
  localparam int ROW_W    = 12;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [FW_BITS-1:0]  FW_RESET  = 10'd512;
  localparam logic [FH_BITS-1:0]  FH_RESET  = 12'd512;
  localparam logic [THR_BITS-1:0] THR_RESET = 11'd50;

  localparam int MIN_DIM = 3;

  // Item kinds carried on tuser
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // Result encoding
  localparam int               EDGE_W     = 8;
  localparam logic [EDGE_W-1:0] EDGE_VALUE = 8'hFF;
  localparam logic [EDGE_W-1:0] FLAT_VALUE = 8'h00;

  // Load enables for the gradient stages
  typedef struct packed {
    logic ld_grad;
    logic ld_square;
  } sobet_adv_t;

endpackage
`default_nettype wire

### src/sobet_line_mem.sv
`default_nettype none
module sobet_line_mem #(
  parameter int DEPTH  = 512,
  parameter int DATA_W = 8
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [DATA_W-1:0]          wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]         rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // read-first: a write to the same address shows up on the next read only
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/sobet_win_cell.sv
`default_nettype none
module sobet_win_cell #(
  parameter int PIXEL_BITS = 8
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           shift_en,
  input  wire  [2:0][PIXEL_BITS-1:0]    col_in,
  output logic [2:0][PIXEL_BITS-1:0]    col_out
);

  logic [2:0][PIXEL_BITS-1:0] col_r;

  // one window column, top row in entry 0; take the right neighbour's column on shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule
`default_nettype wire

### src/sobet_grad.sv
`default_nettype none
module sobet_grad #(
  parameter int PIXEL_BITS = 8
) (
  input  wire                               clk,
  input  wire  sobet_pkg::sobet_adv_t       adv,
  input  wire  [sobet_pkg::THR_BITS-1:0]    edge_threshold,
  input  wire  [2:0][PIXEL_BITS-1:0]        win_left,
  input  wire  [2:0][PIXEL_BITS-1:0]        win_mid,
  input  wire  [2:0][PIXEL_BITS-1:0]        win_right,
  output logic                              is_edge
);
  import sobet_pkg::*;

  localparam int SW    = PIXEL_BITS + 2;
  localparam int HW    = PIXEL_BITS + 3;
  localparam int SQ_W  = 2 * PIXEL_BITS + 4;
  localparam int THQ_W = 2 * THR_BITS;
  localparam int CMP_W = (SQ_W + 1 > THQ_W) ? SQ_W + 1 : THQ_W;

  logic [SW-1:0]          sum_left, sum_right, sum_top, sum_bot;
  logic signed [HW-1:0]   hor_nxt, ver_nxt;
  logic signed [HW-1:0]   hor_r, ver_r;
  logic signed [2*HW-1:0] hor_prod, ver_prod;
  logic [SQ_W-1:0]        hor_sq_r, ver_sq_r;
  logic [THQ_W-1:0]       thr_sq_r;
  logic [CMP_W-1:0]       mag;

  always_comb begin
    sum_left  = SW'(win_left[0]) + (SW'(win_left[1]) << 1) + SW'(win_left[2]);
    sum_right = SW'(win_right[0]) + (SW'(win_right[1]) << 1) + SW'(win_right[2]);
    sum_top   = SW'(win_left[0]) + (SW'(win_mid[0]) << 1) + SW'(win_right[0]);
    sum_bot   = SW'(win_left[2]) + (SW'(win_mid[2]) << 1) + SW'(win_right[2]);
    hor_nxt   = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
    ver_nxt   = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
  end

  assign hor_prod = hor_r * hor_r;
  assign ver_prod = ver_r * ver_r;

  always_ff @(posedge clk) begin
    if (adv.ld_grad) begin
      hor_r <= hor_nxt;
      ver_r <= ver_nxt;
    end
    if (adv.ld_square) begin
      hor_sq_r <= hor_prod[SQ_W-1:0];
      ver_sq_r <= ver_prod[SQ_W-1:0];
    end
    // user sets threshold only while idle (unenforced); lag is harmless
    thr_sq_r <= THQ_W'(edge_threshold) * THQ_W'(edge_threshold);
  end

  assign mag     = CMP_W'(hor_sq_r) + CMP_W'(ver_sq_r);
  assign is_edge = mag > CMP_W'(thr_sq_r);

endmodule
`default_nettype wire

### src/sobel_edge_threshold.sv
// Sobel 3x3 edge detector with threshold on a raster pixel stream.
// Throughput: one transaction per cycle while out_tready does not stall the pipeline; a result reaches
// the output register through the line store read, window, gradient and square stages.
// Results trail the pixel stream by width+1 positions; drain transactions flush the rest.
// Reset (synchronous, rst_n low): registers to defaults, positions and window to zero,
// pipeline emptied; line stores are not cleared.
`default_nettype none
module sobel_edge_threshold #(
  parameter int MAX_WIDTH  = 512,
  parameter int PIXEL_BITS = 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [((PIXEL_BITS+7)/8)*8-1:0]    in_tdata,   // [PIXEL_BITS-1:0] pixel
  input  wire                                in_tuser,   // [0] mode
  // result stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [sobet_pkg::EDGE_W-1:0]       out_tdata,  // [7:0] edge_res
  output logic                               out_tlast,
  // configuration
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire  [sobet_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire  [sobet_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sobet_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import sobet_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW_W0  = $clog2(MAX_WIDTH + 1);
  localparam int EW_W   = (EW_W0 > FW_BITS) ? EW_W0 : FW_BITS;

  // configuration registers
  logic [FW_BITS-1:0]  frame_width_r;
  logic [FH_BITS-1:0]  frame_height_r;
  logic [THR_BITS-1:0] edge_threshold_r;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= FW_RESET;
      frame_height_r   <= FH_RESET;
      edge_threshold_r <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:    frame_width_r    <= cfg_pwdata[FW_BITS-1:0];
        REG_FRAME_HEIGHT:   frame_height_r   <= cfg_pwdata[FH_BITS-1:0];
        REG_EDGE_THRESHOLD: edge_threshold_r <= cfg_pwdata[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:    cfg_prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT:   cfg_prdata = CFG_DATA_W'(frame_height_r);
      REG_EDGE_THRESHOLD: cfg_prdata = CFG_DATA_W'(edge_threshold_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // effective frame size
  logic [EW_W-1:0]  fw_ext, eff_w;
  logic [ROW_W-1:0] eff_h, h_last;
  logic [COL_W-1:0] w_last;

  always_comb begin
    fw_ext = EW_W'(frame_width_r);
    if (fw_ext < EW_W'(MIN_DIM)) begin
      eff_w = EW_W'(MIN_DIM);
    end else if (fw_ext > EW_W'(MAX_WIDTH)) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h  = (frame_height_r < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : frame_height_r;
    w_last = COL_W'(eff_w - EW_W'(1));
    h_last = eff_h - ROW_W'(1);
  end

  // position tracking
  logic [COL_W-1:0] in_col_r, out_col_r, in_col_nxt, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, out_row_r, in_row_nxt, out_row_nxt;
  logic [COL_W-1:0] ic, ocol;
  logic [ROW_W-1:0] ir, orow;
  logic             pix_emit, pix_border;
  logic             out_oob, drn_emit, drn_last;
  logic             in_acc, is_pix;
  logic             item_emit, item_border, item_last;
  logic [PIXEL_BITS-1:0] px_in;

  assign in_acc = in_tvalid && in_tready;
  assign is_pix = (in_tuser == MODE_PIXEL);
  assign px_in  = in_tdata[PIXEL_BITS-1:0];

  always_comb begin
    // move a stale input position back into the frame
    ic = in_col_r;
    ir = in_row_r;
    if (EW_W'(in_col_r) >= eff_w) begin
      ic = '0;
      ir = in_row_r + ROW_W'(1);
    end
    if (ir >= eff_h) begin
      ir = '0;
      ic = '0;
    end

    pix_emit = (ir >= ROW_W'(2)) || ((ir == ROW_W'(1)) && (ic != '0));
    if (ic != '0) begin
      orow = ir - ROW_W'(1);
      ocol = ic - COL_W'(1);
    end else begin
      orow = ir - ROW_W'(2);
      ocol = w_last;
    end
    pix_border = (orow == '0) || (orow == h_last) || (ocol == '0) || (ocol == w_last);

    out_oob  = (out_row_r >= eff_h) || (EW_W'(out_col_r) >= eff_w);
    drn_emit = !out_oob && (in_col_r == '0) && (in_row_r == '0) &&
               !((out_col_r == '0) && (out_row_r == '0));
    drn_last = (out_row_r == h_last) && (out_col_r == w_last);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;

    if (is_pix) begin
      if (ic == w_last) begin
        in_col_nxt = '0;
        in_row_nxt = (ir == h_last) ? '0 : ir + ROW_W'(1);
      end else begin
        in_col_nxt = ic + COL_W'(1);
        in_row_nxt = ir;
      end
      if (!pix_emit) begin
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (ocol == w_last) begin
        out_col_nxt = '0;
        out_row_nxt = orow + ROW_W'(1);
      end else begin
        out_col_nxt = ocol + COL_W'(1);
        out_row_nxt = orow;
      end
    end else if (out_oob) begin
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (drn_emit) begin
      if (out_col_r == w_last) begin
        out_col_nxt = '0;
        out_row_nxt = (out_row_r == h_last) ? '0 : out_row_r + ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end

    item_emit   = is_pix ? pix_emit : drn_emit;
    item_border = is_pix ? pix_border : 1'b1;
    item_last   = !is_pix && drn_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (in_acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // pipeline handshake
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic r1, r2, r3, r4, r_out;

  assign r_out     = !out_valid_r || out_tready;
  assign r4        = !v4_r || r_out;
  assign r3        = !v3_r || r4;
  assign r2        = !v2_r || r3;
  assign r1        = !v1_r || r2;
  assign in_tready = r1;

  // stage 1: line store read
  logic                  pix1_r, emit1_r, border1_r, last1_r;
  logic [COL_W-1:0]      addr1_r;
  logic [PIXEL_BITS-1:0] px1_r;
  logic [PIXEL_BITS-1:0] older_rd, recent_rd;
  logic                  adv12;

  // stages 2 to 4 and output
  logic emit2_r, border2_r, last2_r;
  logic border3_r, last3_r;
  logic border4_r, last4_r;
  logic [EDGE_W-1:0] out_data_r;
  logic              out_last_r;
  logic              is_edge;
  sobet_adv_t        adv;

  assign adv12         = r2 && v1_r && pix1_r;
  assign adv.ld_grad   = r3;
  assign adv.ld_square = r4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop drain transactions with nothing to report at once
      if (r1)    v1_r        <= in_acc && (is_pix || drn_emit);
      if (r2)    v2_r        <= v1_r;
      if (r3)    v3_r        <= v2_r && emit2_r;
      if (r4)    v4_r        <= v3_r;
      if (r_out) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      pix1_r    <= is_pix;
      emit1_r   <= item_emit;
      border1_r <= item_border;
      last1_r   <= item_last;
      addr1_r   <= ic;
      px1_r     <= px_in;
    end
    if (r2) begin
      emit2_r   <= emit1_r;
      border2_r <= border1_r;
      last2_r   <= last1_r;
    end
    if (r3) begin
      border3_r <= border2_r;
      last3_r   <= last2_r;
    end
    if (r4) begin
      border4_r <= border3_r;
      last4_r   <= last3_r;
    end
    if (r_out) begin
      out_data_r <= (!border4_r && is_edge) ? EDGE_VALUE : FLAT_VALUE;
      out_last_r <= last4_r;
    end
  end

  sobet_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_recent_line (
    .clk   (clk),
    .we    (in_acc && is_pix),
    .waddr (ic),
    .wdata (px_in),
    .re    (r1),
    .raddr (ic),
    .rdata (recent_rd)
  );

  // older line takes the recent entry once it has been read out
  sobet_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_older_line (
    .clk   (clk),
    .we    (adv12),
    .waddr (addr1_r),
    .wdata (recent_rd),
    .re    (r1),
    .raddr (ic),
    .rdata (older_rd)
  );

  // window: three column cells, the right one fed from the incoming pixel and the line stores
  logic [2:0][2:0][PIXEL_BITS-1:0] col_q;
  logic [2:0][2:0][PIXEL_BITS-1:0] col_d;

  assign col_d[2] = {px1_r, recent_rd, older_rd};
  assign col_d[1] = col_q[2];
  assign col_d[0] = col_q[1];

  for (genvar j = 0; j < 3; j++) begin : g_win
    sobet_win_cell #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (adv12),
      .col_in   (col_d[j]),
      .col_out  (col_q[j])
    );
  end

  sobet_grad #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_grad (
    .clk            (clk),
    .adv            (adv),
    .edge_threshold (edge_threshold_r),
    .win_left       (col_q[0]),
    .win_mid        (col_q[1]),
    .win_right      (col_q[2]),
    .is_edge        (is_edge)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // the frame end always falls on a border position
  a_last_is_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == FLAT_VALUE)
    else $error("frame end result marked as edge");

  // drain entries only exist when they report a border zero
  a_drain_entry: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !pix1_r |-> emit1_r && border1_r)
    else $error("drain entry without pending border result");

  // older line write must never hit the column being read
  a_line_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    adv12 && in_acc && is_pix |-> addr1_r != ic)
    else $error("line store write and read collide");

  // a result leaving the square stage lands in the output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && r_out |=> out_tvalid)
    else $error("result lost between square stage and output");
`endif

endmodule
`default_nettype wire
